// File: rtl/core/ppr_pkg.sv
// Shared types, codes and helpers of the phase-polynomial rz merger.
package ppr_pkg;

   localparam int ANGLE_W = 32;
   localparam int SA_W    = 33;
   localparam int SUM_W   = 40;
   localparam int NODE_W  = 16;
   localparam int EPS_W   = 24;

   // command word between front and back: {flush, key, negated, signed angle, node}
   localparam int CMD_NODE_LSB = 0;
   localparam int CMD_SA_LSB   = CMD_NODE_LSB + NODE_W;
   localparam int CMD_NEG_BIT  = CMD_SA_LSB + SA_W;
   localparam int CMD_KEY_LSB  = CMD_NEG_BIT + 1;
   localparam int CMD_FIXED_W  = CMD_KEY_LSB + 1;

   localparam logic [1:0] REQ_CX  = 2'd0;
   localparam logic [1:0] REQ_X   = 2'd1;
   localparam logic [1:0] REQ_RZ  = 2'd2;
   localparam logic [1:0] REQ_END = 2'd3;

   localparam logic [1:0] ACT_REMOVE = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_FULL   = 2'd2;
   localparam logic [1:0] ACT_EMPTY  = 2'd3;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]               req_type;
      logic [3:0]               qubit_a;
      logic [3:0]               qubit_b;
      logic signed [ANGLE_W-1:0] angle;
      logic [NODE_W-1:0]        node_id;
   } req_item_type;

   typedef struct packed {
      logic [1:0]              action;
      logic [NODE_W-1:0]       out_node_id;
      logic signed [SUM_W-1:0] new_angle;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [NODE_W-1:0]       first_node;
      logic                    negated;
   } mono_entry_type;

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/phase_polynomial_rz_merger_top.sv
// Top level of the phase-polynomial rz merger.
//
// req_* carries gate beats (cx, x, rz, end of block); rsp_* carries result beats
// (remove node, set node angle, table full, empty block). csr_* writes the zero
// epsilon and is always ready; write it only while the block is idle.
// cx and x beats are absorbed by the front end and give no result.
// rz and end-of-block beats pass through a QUEUE_DEPTH-entry command queue, so
// the front end takes one beat per cycle until that queue fills.
// The table side handles a new monomial or a full-table error with the tag compare
// alone, and a repeat with a further read-modify-write of the entry memory; a
// result appears in the cycle after it is produced.
// An end-of-block flush does one memory read and gives one result per entry,
// and marks its final beat with last.
// A stalled result is held in the output register; the table side waits and the
// queue backs up into req_stall.
// Synchronous reset empties the queue and the table, restores each qubit mask to
// its unit vector and clears the epsilon; no clearing pass is needed.
module phase_polynomial_rz_merger_top #(
   parameter int NUM_QUBITS   = 16,
   parameter int MONO_ENTRIES = 32,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ppr_pkg::req_item_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ppr_pkg::rsp_item_type      rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ppr_pkg::EPS_W-1:0]  csr_data
);

   import ppr_pkg::*;

   localparam int CMD_W = NUM_QUBITS + CMD_FIXED_W;

   logic             push, pop, full, empty;
   logic [CMD_W-1:0] push_data, pop_data;

   assign csr_ready = 1'b1;

   ppr_front #(
      .NUM_QUBITS (NUM_QUBITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   ppr_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   ppr_back #(
      .NUM_QUBITS   (NUM_QUBITS),
      .MONO_ENTRIES (MONO_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/ppr_queue.sv
// Short command queue between the gate front end and the monomial table.
module ppr_queue #(
   parameter int DATA_W = 67,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/ppr_front.sv
// Gate front end: qubit parity masks, cx and x updates, rz and end-of-block commands.
module ppr_front #(
   parameter int NUM_QUBITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ppr_pkg::req_item_type   req_data,
   output logic                    push,
   output logic [NUM_QUBITS+50:0]  push_data,
   input  logic                    full
);

   import ppr_pkg::*;

   localparam int MASK_W = NUM_QUBITS + 1;
   localparam int QIDX_W = $clog2(NUM_QUBITS);

   logic [MASK_W-1:0] mask_ff [NUM_QUBITS];
   logic [MASK_W-1:0] mask_in [NUM_QUBITS];
   logic              accept;
   logic              qa_ok, qb_ok;
   logic [QIDX_W-1:0] a_idx, b_idx;
   logic [MASK_W-1:0] mask_a;
   logic              neg;
   logic signed [SA_W-1:0] ang_ext, sa;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign qa_ok     = int'(req_data.qubit_a) < NUM_QUBITS;
   assign qb_ok     = int'(req_data.qubit_b) < NUM_QUBITS;
   assign a_idx     = QIDX_W'(req_data.qubit_a);
   assign b_idx     = QIDX_W'(req_data.qubit_b);
   assign mask_a    = mask_ff[a_idx];
   assign neg       = mask_a[0];
   assign ang_ext   = {req_data.angle[ANGLE_W-1], req_data.angle};
   assign sa        = neg ? -ang_ext : ang_ext;
   assign push_data = {(req_data.req_type == REQ_END), mask_a[MASK_W-1:1], neg, sa,
                       req_data.node_id};

   always_comb begin
      mask_in = mask_ff;
      push    = 1'b0;
      if (accept) begin
         case (req_data.req_type)
            REQ_CX: begin
               if (qa_ok && qb_ok) begin
                  for (int q = 0; q < NUM_QUBITS; q++) begin
                     if (QIDX_W'(q) == b_idx) begin
                        mask_in[q] = mask_ff[q] ^ mask_a;
                     end
                  end
               end
            end
            REQ_X: begin
               if (qa_ok) begin
                  for (int q = 0; q < NUM_QUBITS; q++) begin
                     if (QIDX_W'(q) == a_idx) begin
                        mask_in[q][0] = ~mask_ff[q][0];
                     end
                  end
               end
            end
            REQ_RZ: begin
               push = qa_ok;
            end
            REQ_END: begin
               push = 1'b1;
               for (int q = 0; q < NUM_QUBITS; q++) begin
                  mask_in[q] = MASK_W'(1) << (q + 1);
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUBITS; q++) begin
            mask_ff[q] <= MASK_W'(1) << (q + 1);
         end
      end else begin
         mask_ff <= mask_in;
      end
   end

endmodule

// File: rtl/core/ppr_back.sv
// Monomial table: associative lookup, saturating accumulate and end-of-block flush.
module ppr_back #(
   parameter int NUM_QUBITS   = 16,
   parameter int MONO_ENTRIES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [ppr_pkg::EPS_W-1:0]        csr_data,
   output logic                             pop,
   input  logic [NUM_QUBITS+50:0]           pop_data,
   input  logic                             empty,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppr_pkg::rsp_item_type            rsp_data
);

   import ppr_pkg::*;

   localparam int KEY_W  = NUM_QUBITS;
   localparam int CMD_W  = NUM_QUBITS + CMD_FIXED_W;
   localparam int SLOT_W = (MONO_ENTRIES > 1) ? $clog2(MONO_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MONO_ENTRIES + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOK   = 5'b00010,
      ST_ACC    = 5'b00100,
      ST_FSTART = 5'b01000,
      ST_FOUT   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]  key_ff [MONO_ENTRIES];
   mono_entry_type    mono_ff [MONO_ENTRIES];
   mono_entry_type    rd_ff;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0] flush_ff, flush_in;
   logic [EPS_W-1:0]  eps_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_data_ff;

   logic [NODE_W-1:0]       c_node;
   logic signed [SA_W-1:0]  c_sa;
   logic                    c_neg;
   logic [KEY_W-1:0]        c_key;
   logic                    cmd_load;
   logic [MONO_ENTRIES-1:0] hit_vec;
   logic                    hit;
   logic [SLOT_W-1:0]       hit_idx;
   logic                    table_full;
   logic                    out_free;
   logic                    emit;
   rsp_item_type            emit_data;
   logic                    wr_en, key_wr;
   logic [SLOT_W-1:0]       wr_addr;
   mono_entry_type          wr_data;
   logic                    rd_en;
   logic [SLOT_W-1:0]       rd_addr;
   logic signed [SUM_W:0]   acc_sum, rd_wide, mag;
   logic                    f_zero, f_last;
   logic signed [SUM_W-1:0] f_angle;

   assign c_node = cmd_ff[CMD_NODE_LSB +: NODE_W];
   assign c_sa   = cmd_ff[CMD_SA_LSB +: SA_W];
   assign c_neg  = cmd_ff[CMD_NEG_BIT];
   assign c_key  = cmd_ff[CMD_KEY_LSB +: KEY_W];

   assign table_full = (used_ff == CNT_W'(MONO_ENTRIES));
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      hit_idx = '0;
      for (int s = 0; s < MONO_ENTRIES; s++) begin
         hit_vec[s] = (CNT_W'(s) < used_ff) && (key_ff[s] == c_key);
         if (hit_vec[s]) begin
            hit_idx = hit_idx | SLOT_W'(s);
         end
      end
      hit = |hit_vec;
   end

   assign acc_sum = {rd_ff.sum[SUM_W-1], rd_ff.sum} + {{(SUM_W + 1 - SA_W){c_sa[SA_W-1]}}, c_sa};
   assign rd_wide = {rd_ff.sum[SUM_W-1], rd_ff.sum};
   assign mag     = rd_wide[SUM_W] ? -rd_wide : rd_wide;
   assign f_zero  = mag <= {{(SUM_W + 1 - EPS_W){1'b0}}, eps_ff};
   assign f_angle = rd_ff.negated ? sat_sum(-rd_wide) : rd_ff.sum;
   assign f_last  = (CNT_W'(flush_ff) + 1'b1) == used_ff;

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      flush_in  = flush_ff;
      pop       = 1'b0;
      cmd_load  = 1'b0;
      emit      = 1'b0;
      emit_data = '0;
      wr_en     = 1'b0;
      key_wr    = 1'b0;
      wr_addr   = used_ff[SLOT_W-1:0];
      wr_data   = '{sum: {{(SUM_W - SA_W){c_sa[SA_W-1]}}, c_sa}, first_node: c_node,
                    negated: c_neg};
      rd_en     = 1'b0;
      rd_addr   = flush_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cmd_load = 1'b1;
               state_in = pop_data[CMD_W-1] ? ST_FSTART : ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (hit) begin
               if (out_free) begin
                  emit                  = 1'b1;
                  emit_data.action      = ACT_REMOVE;
                  emit_data.out_node_id = c_node;
                  rd_en                 = 1'b1;
                  rd_addr               = hit_idx;
                  state_in              = ST_ACC;
               end
            end else if (table_full) begin
               if (out_free) begin
                  emit                  = 1'b1;
                  emit_data.action      = ACT_FULL;
                  emit_data.out_node_id = c_node;
                  state_in              = ST_IDLE;
               end
            end else begin
               wr_en    = 1'b1;
               key_wr   = 1'b1;
               used_in  = used_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ACC: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx;
            wr_data  = '{sum: sat_sum(acc_sum), first_node: rd_ff.first_node,
                         negated: rd_ff.negated};
            state_in = ST_IDLE;
         end
         ST_FSTART: begin
            flush_in = '0;
            if (used_ff == '0) begin
               if (out_free) begin
                  emit             = 1'b1;
                  emit_data.action = ACT_EMPTY;
                  emit_data.last   = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_FOUT;
            end
         end
         ST_FOUT: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_data.action      = f_zero ? ACT_REMOVE : ACT_SET;
               emit_data.out_node_id = rd_ff.first_node;
               emit_data.new_angle   = f_zero ? '0 : f_angle;
               emit_data.last        = f_last;
               if (f_last) begin
                  used_in  = '0;
                  flush_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  flush_in = flush_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = flush_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         flush_ff     <= '0;
         eps_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            eps_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff <= pop_data;
      end
      if (emit) begin
         out_data_ff <= emit_data;
      end
      if (key_wr) begin
         key_ff[wr_addr] <= c_key;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mono_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mono_ff[rd_addr];
      end
   end

endmodule
